/* rtl/cmd_pkg.sv */
// Shared types and constants for the chorus modulated delay block.
`default_nettype none
package cmd_pkg;

  // Frame geometry and configuration port
  localparam int FRAME_CH   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register field widths
  localparam int BASE_W  = 21;
  localparam int DEPTH_W = 15;
  localparam int FB_W    = 16;
  localparam int WET_W   = 16;
  localparam int INC_W   = 32;
  localparam int CC_W    = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_INC    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CH_COUNT   = 3'd5;

  // Register reset values
  localparam logic [BASE_W-1:0]  RST_BASE_DELAY = 21'd256000;
  localparam logic [DEPTH_W-1:0] RST_MOD_DEPTH  = 15'd16384;
  localparam logic [FB_W-1:0]    RST_FEEDBACK   = 16'd0;
  localparam logic [WET_W-1:0]   RST_WET        = 16'd16384;
  localparam logic [INC_W-1:0]   RST_LFO_INC    = 32'd0;
  localparam logic [CC_W-1:0]    RST_CH_COUNT   = 4'd2;

  // Unity gain in Q1.15
  localparam logic [16:0] GAIN_UNITY = 17'd32768;

  // Sine polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [16:0] SIN_B = 17'd42047;
  localparam logic [16:0] SIN_C = 17'd4640;

  // Top-level sequencer
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MOD, ST_RD1, ST_RD2, ST_MAC2, ST_FBK, ST_WET, ST_DRY, ST_WB
  } cmd_state_t;

  // Steps of the shared modulation multiplier
  typedef enum logic [2:0] {
    MS_SQR, MS_C, MS_B, MS_Y, MS_DEPTH, MS_BASE, MS_PTR
  } mod_step_t;

  // Per-step strobes to the lanes
  typedef struct packed {
    logic mac1;
    logic mac2;
    logic fbk;
    logic wet;
    logic dry;
    logic wb;
    logic clr;
  } lane_ctl_t;

endpackage
`default_nettype wire

/* rtl/chorus_modulated_delay.sv */
// Chorus: modulated delay line with feedback and dry/wet mix over parallel lanes.
// Each accepted word goes through the seven-step modulation multiplier, then the lane
// read/multiply/write-back sequence that loads the output register.
// One word at a time: the input is not ready again until that word is written back,
// and write-back waits while the output register holds an untaken word.
// Reset: synchronous active-low; then a clearing pass over every delay address zeros
// every delay store, with the input held not ready (configuration writes still taken).
`default_nettype none
module chorus_modulated_delay import cmd_pkg::*; #(
  parameter int DELAY_DEPTH     = 8192,
  parameter int LANES           = 8,
  parameter int SAMPLE_BITS     = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_0,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_1,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_2,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_3,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_4,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_5,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_6,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_7,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_0,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_1,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_2,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_3,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_4,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_5,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_6,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_7,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SB = SAMPLE_BITS;
  localparam logic [AW-1:0]   LAST_L  = AW'(DELAY_DEPTH - 1);
  localparam logic [CC_W-1:0] LANES_L = CC_W'(LANES);

  cmd_state_t state_r, state_nxt;

  logic [BASE_W-1:0]  base_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [FB_W-1:0]    fb_r;
  logic [WET_W-1:0]   wet_r;
  logic [INC_W-1:0]   inc_r;
  logic [CC_W-1:0]    cc_r;
  logic [31:0]        phase_r;
  logic [AW-1:0]      wp_r, clr_r;

  logic               in_acc, out_free, mod_done;
  logic [7:0]         frac;
  logic [AW-1:0]      rp1, rp2, raddr, waddr;
  lane_ctl_t          ctl;
  logic [16:0]        wet_eff, dry_eff;
  logic [CC_W-1:0]    lanes_on;
  logic [LANES-1:0]   active;
  logic [FRAME_CH-1:0][SB-1:0] frame_in, frame_x, out_frame;
  logic [LANES-1:0][SB-1:0]    lane_y;

  assign frame_in = {in_sample_7, in_sample_6, in_sample_5, in_sample_4,
                     in_sample_3, in_sample_2, in_sample_1, in_sample_0};
  assign out_sample_0 = out_frame[0];
  assign out_sample_1 = out_frame[1];
  assign out_sample_2 = out_frame[2];
  assign out_sample_3 = out_frame[3];
  assign out_sample_4 = out_frame[4];
  assign out_sample_5 = out_frame[5];
  assign out_sample_6 = out_frame[6];
  assign out_sample_7 = out_frame[7];

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= RST_BASE_DELAY;
      depth_r <= RST_MOD_DEPTH;
      fb_r    <= RST_FEEDBACK;
      wet_r   <= RST_WET;
      inc_r   <= RST_LFO_INC;
      cc_r    <= RST_CH_COUNT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_DELAY: base_r  <= cfg_data[BASE_W-1:0];
        REG_MOD_DEPTH:  depth_r <= cfg_data[DEPTH_W-1:0];
        REG_FEEDBACK:   fb_r    <= cfg_data[FB_W-1:0];
        REG_WET:        wet_r   <= cfg_data[WET_W-1:0];
        REG_LFO_INC:    inc_r   <= cfg_data[INC_W-1:0];
        REG_CH_COUNT:   cc_r    <= cfg_data[CC_W-1:0];
        default: ;
      endcase
    end
  end

  // derived gains and lane mask
  always_comb begin
    wet_eff  = ({1'b0, wet_r} > GAIN_UNITY) ? GAIN_UNITY : {1'b0, wet_r};
    dry_eff  = GAIN_UNITY - wet_eff;
    lanes_on = (cc_r > LANES_L) ? LANES_L : cc_r;
    for (int i = 0; i < LANES; i++) begin
      active[i] = CC_W'(i) < lanes_on;
    end
  end

  assign in_acc   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == LAST_L) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = ST_MOD;
      ST_MOD:   if (mod_done) state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_MAC2;
      ST_MAC2:  state_nxt = ST_FBK;
      ST_FBK:   state_nxt = ST_WET;
      ST_WET:   state_nxt = ST_DRY;
      ST_DRY:   state_nxt = ST_WB;
      ST_WB:    if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    raddr    = rp2;
    waddr    = wp_r;
    case (state_r)
      ST_CLEAR: begin
        ctl.clr = 1'b1;
        waddr   = clr_r;
      end
      ST_IDLE:  in_ready = 1'b1;
      ST_RD1:   raddr = rp1;
      ST_RD2:   ctl.mac1 = 1'b1;
      ST_MAC2:  ctl.mac2 = 1'b1;
      ST_FBK:   ctl.fbk = 1'b1;
      ST_WET:   ctl.wet = 1'b1;
      ST_DRY:   ctl.dry = 1'b1;
      ST_WB:    ctl.wb = out_free;
      default: ;
    endcase
  end

  // state, pointers and phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      wp_r    <= '0;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (in_acc) begin
        phase_r <= phase_r + inc_r;
      end
      if (ctl.wb) begin
        wp_r <= (wp_r == LAST_L) ? '0 : wp_r + AW'(1);
      end
    end
  end

  cmd_mod #(.DELAY_DEPTH(DELAY_DEPTH), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc),
    .phase      (phase_r),
    .wp         (wp_r),
    .base_delay (base_r),
    .mod_depth  (depth_r),
    .done       (mod_done),
    .frac       (frac),
    .rp1        (rp1),
    .rp2        (rp2)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    cmd_lane #(.DELAY_DEPTH(DELAY_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .active  (active[g]),
      .raddr   (raddr),
      .waddr   (waddr),
      .frac    (frac),
      .fb_gain ($signed(fb_r)),
      .wet     (wet_eff),
      .dry     (dry_eff),
      .x_in    ($signed(frame_x[g])),
      .y_out   (lane_y[g])
    );
  end

  cmd_merge #(.LANES(LANES), .SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .frame_in  (frame_in),
    .frame_x   (frame_x),
    .wb        (ctl.wb),
    .active    (active),
    .lane_y    (lane_y),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_frame (out_frame)
  );

endmodule
`default_nettype wire

/* rtl/cmd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cmd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/cmd_mod.sv */
// LFO evaluation and delay pointer computation on one shared multiplier.
`default_nettype none
module cmd_mod import cmd_pkg::*; #(
  parameter int DELAY_DEPTH     = 8192,
  parameter int SINE_TABLE_BITS = 10,
  localparam int AW = $clog2(DELAY_DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [31:0]        phase,
  input  wire logic [AW-1:0]      wp,
  input  wire logic [BASE_W-1:0]  base_delay,
  input  wire logic [DEPTH_W-1:0] mod_depth,
  output logic                    done,
  output logic [7:0]              frac,
  output logic [AW-1:0]           rp1,
  output logic [AW-1:0]           rp2
);

  localparam int QB = SINE_TABLE_BITS - 2;
  localparam int DW = 23;
  localparam logic [DW-1:0] D_LO = 23'd256;
  localparam logic [DW-1:0] D_HI = DW'((DELAY_DEPTH - 1) * 256);
  localparam logic [AW:0]   DEPTH_L = (AW + 1)'(DELAY_DEPTH);
  localparam logic [AW-1:0] LAST_L  = AW'(DELAY_DEPTH - 1);

  logic                 busy_r;
  mod_step_t            step_r;
  logic [16:0]          x_r, x2_r, t1_r, t2_r;
  logic                 neg_r;
  logic signed [15:0]   lfo_r;
  logic signed [31:0]   fac_r;
  logic [DW-1:0]        d_r;
  logic [7:0]           f_r;
  logic [AW-1:0]        rp1_r, rp2_r;
  logic                 done_r;

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [QB:0]          xq;
  logic [16:0]          x_start;
  logic signed [31:0]   ma, mb;
  logic signed [63:0]   prod;
  logic [16:0]          y;
  logic [15:0]          yh;
  logic [14:0]          ymag;
  logic [DW-1:0]        dprod;
  logic [AW-1:0]        n;
  logic [AW:0]          rsum;
  logic [AW-1:0]        rp1_c;

  // fold the phase into the first quadrant
  always_comb begin
    idx = phase[31 -: SINE_TABLE_BITS];
    if (idx[QB]) begin
      xq = {1'b1, {QB{1'b0}}} - {1'b0, idx[QB-1:0]};
    end else begin
      xq = {1'b0, idx[QB-1:0]};
    end
    x_start = 17'(xq) << (16 - QB);
  end

  // operand select for the shared multiplier
  always_comb begin
    case (step_r)
      MS_SQR:   begin ma = {15'b0, x_r};  mb = {15'b0, x_r};  end
      MS_C:     begin ma = {15'b0, x2_r}; mb = {15'b0, SIN_C}; end
      MS_B:     begin ma = {15'b0, x2_r}; mb = {15'b0, t1_r}; end
      MS_Y:     begin ma = {15'b0, x_r};  mb = {15'b0, t2_r}; end
      MS_DEPTH: begin ma = {17'b0, mod_depth}; mb = {{16{lfo_r[15]}}, lfo_r}; end
      MS_BASE:  begin ma = {11'b0, base_delay}; mb = fac_r; end
      default:  begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
  end

  // shape results of each step
  always_comb begin
    y     = prod[32:16];
    yh    = y[16:1];
    ymag  = (yh > 16'd32767) ? 15'h7FFF : yh[14:0];
    dprod = prod[52:30];
    n     = d_r[AW+7:8];
    rsum  = {1'b0, wp} + DEPTH_L - {1'b0, n};
    if (rsum >= DEPTH_L) begin
      rsum = rsum - DEPTH_L;
    end
    rp1_c = rsum[AW-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= MS_SQR;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= MS_SQR;
      end else if (busy_r) begin
        case (step_r)
          MS_SQR:   step_r <= MS_C;
          MS_C:     step_r <= MS_B;
          MS_B:     step_r <= MS_Y;
          MS_Y:     step_r <= MS_DEPTH;
          MS_DEPTH: step_r <= MS_BASE;
          MS_BASE:  step_r <= MS_PTR;
          default: begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x_start;
      neg_r <= idx[QB+1];
    end else if (busy_r) begin
      case (step_r)
        MS_SQR:   x2_r <= prod[32:16];
        MS_C:     t1_r <= SIN_B - prod[32:16];
        MS_B:     t2_r <= SIN_A - prod[32:16];
        MS_Y:     lfo_r <= neg_r ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});
        MS_DEPTH: fac_r <= 32'sh4000_0000 + prod[31:0];
        MS_BASE: begin
          if (dprod < D_LO) begin
            d_r <= D_LO;
          end else if (dprod > D_HI) begin
            d_r <= D_HI;
          end else begin
            d_r <= dprod;
          end
        end
        default: begin
          f_r   <= d_r[7:0];
          rp1_r <= rp1_c;
          rp2_r <= (rp1_c == '0) ? LAST_L : rp1_c - AW'(1);
        end
      endcase
    end
  end

  assign done = done_r;
  assign frac = f_r;
  assign rp1  = rp1_r;
  assign rp2  = rp2_r;

endmodule
`default_nettype wire

/* rtl/cmd_lane.sv */
// One channel: delay store, interpolation, feedback and dry/wet mix.
`default_nettype none
module cmd_lane import cmd_pkg::*; #(
  parameter int DELAY_DEPTH = 8192,
  parameter int SAMPLE_BITS = 24,
  localparam int AW = $clog2(DELAY_DEPTH),
  localparam int SB = SAMPLE_BITS
) (
  input  wire logic                 clk,
  input  wire lane_ctl_t            ctl,
  input  wire logic                 active,
  input  wire logic [AW-1:0]        raddr,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [7:0]           frac,
  input  wire logic signed [15:0]   fb_gain,
  input  wire logic [16:0]          wet,
  input  wire logic [16:0]          dry,
  input  wire logic signed [SB-1:0] x_in,
  output logic signed [SB-1:0]      y_out
);

  localparam logic signed [SB+4:0] SMAX = (SB + 5)'((64'sd1 <<< (SB - 1)) - 1);
  localparam logic signed [SB+4:0] SMIN = -SMAX - 1;

  logic [SB-1:0]           rdata;
  logic signed [SB-1:0]    s;
  logic signed [SB+9:0]    p_r, acc_r;
  logic signed [SB+1:0]    dl, dl_r;
  logic signed [SB+17:0]   fb_r;
  logic signed [SB+18:0]   wm_r;
  logic signed [SB+19:0]   sum_r;
  logic signed [9:0]       w_old, w_new;
  logic signed [SB+4:0]    st_sum, mix_sh;
  logic signed [SB-1:0]    st_sat, mix_sat;
  logic                    we;
  logic [SB-1:0]           wdata;

  function automatic logic signed [SB-1:0] sat(input logic signed [SB+4:0] v);
    logic signed [SB+4:0] c;
    c = v;
    if (v > SMAX) begin
      c = SMAX;
    end else if (v < SMIN) begin
      c = SMIN;
    end
    return c[SB-1:0];
  endfunction

  cmd_ram #(.WIDTH(SB), .DEPTH(DELAY_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // interpolation weights and write-back values
  always_comb begin
    s      = $signed(rdata);
    w_old  = $signed(10'd256 - {2'b0, frac});
    w_new  = $signed({2'b0, frac});
    dl     = $signed(acc_r[SB+9:8]);
    st_sum = (SB + 5)'(x_in) + (SB + 5)'($signed(fb_r[SB+17:15]));
    mix_sh = sum_r[SB+19:15];
    st_sat = sat(st_sum);
    mix_sat = sat(mix_sh);
    we     = ctl.clr | (ctl.wb & active);
    wdata  = ctl.clr ? '0 : st_sat;
  end

  // multiply-accumulate sequence
  always_ff @(posedge clk) begin
    if (ctl.mac1) begin
      p_r <= s * w_old;
    end
    if (ctl.mac2) begin
      acc_r <= p_r + s * w_new;
    end
    if (ctl.fbk) begin
      dl_r <= dl;
      fb_r <= dl * fb_gain;
    end
    if (ctl.wet) begin
      wm_r <= dl_r * $signed({1'b0, wet});
    end
    if (ctl.dry) begin
      sum_r <= (SB + 20)'(wm_r)
             + (SB + 20)'(x_in) * (SB + 20)'($signed({1'b0, dry}));
    end
  end

  // mixed sample, held from the dry step until the merge stage takes it
  assign y_out = mix_sat;

endmodule
`default_nettype wire

/* rtl/cmd_merge.sv */
// Frame capture and output register: joins lane results with pass-through lanes.
`default_nettype none
module cmd_merge import cmd_pkg::*; #(
  parameter int LANES       = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   load,
  input  wire logic [FRAME_CH-1:0][SAMPLE_BITS-1:0]   frame_in,
  output logic      [FRAME_CH-1:0][SAMPLE_BITS-1:0]   frame_x,
  input  wire logic                                   wb,
  input  wire logic [LANES-1:0]                       active,
  input  wire logic [LANES-1:0][SAMPLE_BITS-1:0]      lane_y,
  input  wire logic                                   out_ready,
  output logic                                        out_valid,
  output logic      [FRAME_CH-1:0][SAMPLE_BITS-1:0]   out_frame
);

  logic [FRAME_CH-1:0][SAMPLE_BITS-1:0] x_r, o_r;
  logic                                 v_r;

  // hold the accepted input word
  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= frame_in;
    end
  end

  // merge lane results; inactive and missing lanes pass their input
  always_ff @(posedge clk) begin
    if (wb) begin
      for (int i = 0; i < FRAME_CH; i++) begin
        o_r[i] <= x_r[i];
        if (i < LANES) begin
          if (active[i]) begin
            o_r[i] <= lane_y[i];
          end
        end
      end
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (wb) begin
      v_r <= 1'b1;
    end else if (out_ready) begin
      v_r <= 1'b0;
    end
  end

  assign frame_x   = x_r;
  assign out_valid = v_r;
  assign out_frame = o_r;

endmodule
`default_nettype wire

/* rtl/cmd_chk.sv */
// Port-level checks for the chorus block, bound to the top level.
`default_nettype none
module cmd_chk import cmd_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] out_sample_0
);

  // a stalled output word stays valid and its sample 0 holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_0))
    else $error("output word changed while stalled");

  // reset starts the clearing pass with the input closed
  a_reset_closed: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // one word in flight: accept closes the input
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in flight");

endmodule

bind chorus_modulated_delay cmd_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_cmd_chk (.*);
`default_nettype wire

/* sim/chorus_modulated_delay_checker.sv */
// Checker for the chorus block: tracks its settings, predicts each frame and compares.
module chorus_modulated_delay_checker import cmd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [FRAME_CH-1:0][23:0] in_frame,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [FRAME_CH-1:0][23:0] out_frame,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       mix_errors = 0,
  output int                       frames_due = 0
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 8192;
  localparam longint SAMPLE_MAX = 64'sd8388607;
  localparam longint SAMPLE_MIN = -64'sd8388608;

  typedef logic [FRAME_CH-1:0][23:0] frame_t;

  // Model state and settings
  logic signed [23:0] echo_store [FRAME_CH][STORE_DEPTH];
  int unsigned        wr_ptr;
  logic [31:0]        lfo_phase_q;
  logic [BASE_W-1:0]  base_delay_q;
  logic [DEPTH_W-1:0] mod_depth_q;
  logic signed [15:0] fb_gain_q;
  logic [WET_W-1:0]   wet_gain_q;
  logic [INC_W-1:0]   lfo_inc_q;
  logic [CC_W-1:0]    ch_count_q;
  frame_t             mix_due [$];

  initial begin
    for (int c = 0; c < FRAME_CH; c++)
      for (int i = 0; i < STORE_DEPTH; i++) echo_store[c][i] = '0;
  end

  function automatic longint clip24(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  // Sine approximation from the top ten phase bits, Q1.15
  function automatic longint sine_at(logic [31:0] ph);
    logic [9:0] idx;
    longint unsigned x, x2, t, y;
    idx = ph[31:22];
    x = idx[8] ? 64'd256 - idx[7:0] : 64'(idx[7:0]);
    x = x << 8;
    x2 = (x * x) >> 16;
    t = 64'(SIN_B) - ((x2 * 64'(SIN_C)) >> 16);
    t = 64'(SIN_A) - ((x2 * t) >> 16);
    y = ((x * t) >> 16) >> 1;
    if (y > 32767) y = 32767;
    return idx[9] ? -longint'(y) : longint'(y);
  endfunction

  // Work out one output frame and update the delay stores
  function automatic frame_t chorus_frame(frame_t dry_in);
    frame_t res;
    longint lfo, factor, d, wet, dry, x, delayed;
    int unsigned n, f, rp1, rp2, lanes_on;
    lfo = sine_at(lfo_phase_q);
    lfo_phase_q = lfo_phase_q + lfo_inc_q;
    factor = (64'sd1 << 30) + longint'(mod_depth_q) * lfo;
    d = (longint'(base_delay_q) * factor) >>> 30;
    if (d < 256) d = 256;
    if (d > (STORE_DEPTH - 1) * 256) d = (STORE_DEPTH - 1) * 256;
    n = int'(d >>> 8);
    f = int'(d & 255);
    rp1 = (wr_ptr + STORE_DEPTH - n) % STORE_DEPTH;
    rp2 = (rp1 + STORE_DEPTH - 1) % STORE_DEPTH;
    wet = (wet_gain_q > 32768) ? 32768 : longint'(wet_gain_q);
    dry = 32768 - wet;
    lanes_on = (ch_count_q > FRAME_CH) ? FRAME_CH : ch_count_q;
    for (int c = 0; c < FRAME_CH; c++) begin
      x = longint'(signed'(dry_in[c]));
      if (c >= lanes_on) begin
        res[c] = dry_in[c];
        continue;
      end
      delayed = (longint'(echo_store[c][rp1]) * longint'(256 - f)
                 + longint'(echo_store[c][rp2]) * longint'(f)) >>> 8;
      echo_store[c][wr_ptr] = 24'(clip24(x + ((delayed * longint'(fb_gain_q)) >>> 15)));
      res[c] = 24'(clip24((dry * x + wet * delayed) >>> 15));
    end
    wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
    return res;
  endfunction

  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      wr_ptr       = 0;
      lfo_phase_q  = '0;
      base_delay_q = RST_BASE_DELAY;
      mod_depth_q  = RST_MOD_DEPTH;
      fb_gain_q    = RST_FEEDBACK;
      wet_gain_q   = RST_WET;
      lfo_inc_q    = RST_LFO_INC;
      ch_count_q   = RST_CH_COUNT;
      mix_due.delete();
    end else begin
      // Take register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_DELAY: base_delay_q = cfg_data[BASE_W-1:0];
          REG_MOD_DEPTH:  mod_depth_q  = cfg_data[DEPTH_W-1:0];
          REG_FEEDBACK:   fb_gain_q    = cfg_data[FB_W-1:0];
          REG_WET:        wet_gain_q   = cfg_data[WET_W-1:0];
          REG_LFO_INC:    lfo_inc_q    = cfg_data[INC_W-1:0];
          REG_CH_COUNT:   ch_count_q   = cfg_data[CC_W-1:0];
          default: ;
        endcase
      end
      // Compare an output word with the oldest prediction
      if (out_valid && out_ready) begin
        if (mix_due.size() == 0) begin
          $display("%0t: unexpected output word %h", $time, out_frame);
          mix_errors++;
        end else begin
          want = mix_due.pop_front();
          for (int c = 0; c < FRAME_CH; c++)
            if (out_frame[c] !== want[c]) begin
              $display("%0t: lane %0d expected %h got %h", $time, c, want[c], out_frame[c]);
              mix_errors++;
            end
        end
      end
      // Predict each accepted input word
      if (in_valid && in_ready) mix_due.push_back(chorus_frame(in_frame));
    end
    frames_due = mix_due.size();
  end

  final begin
    if (mix_due.size() != 0) $display("%0d output words never arrived", mix_due.size());
  end
endmodule

/* sim/chorus_modulated_delay_test.sv */
// Top of the chorus testbench: clock, reset, stimulus, settings and verdict.
module chorus_modulated_delay_test import cmd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [FRAME_CH-1:0][23:0] frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  frame_t in_frame = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  frame_t out_frame;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int mix_errors;
  int frames_due;
  int tx_idle_pct;
  int rx_idle_pct = 0;

  always #4 clk = ~clk;

  chorus_modulated_delay i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_0(in_frame[0]), .in_sample_1(in_frame[1]),
    .in_sample_2(in_frame[2]), .in_sample_3(in_frame[3]),
    .in_sample_4(in_frame[4]), .in_sample_5(in_frame[5]),
    .in_sample_6(in_frame[6]), .in_sample_7(in_frame[7]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sample_0(out_frame[0]), .out_sample_1(out_frame[1]),
    .out_sample_2(out_frame[2]), .out_sample_3(out_frame[3]),
    .out_sample_4(out_frame[4]), .out_sample_5(out_frame[5]),
    .out_sample_6(out_frame[6]), .out_sample_7(out_frame[7]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  chorus_modulated_delay_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_frame(in_frame),
    .out_valid(out_valid), .out_ready(out_ready), .out_frame(out_frame),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mix_errors(mix_errors), .frames_due(frames_due)
  );

  // Stall the output side at random
  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  // Write all six registers back to back, dropping valid after the last
  task automatic write_settings(logic [31:0] base, logic [31:0] depth, logic [31:0] fb,
                                logic [31:0] wet, logic [31:0] inc, logic [31:0] cc);
    logic [31:0] vals [6];
    logic [CFG_IDX_W-1:0] regs [6];
    vals = '{base, depth, fb, wet, inc, cc};
    regs = '{REG_BASE_DELAY, REG_MOD_DEPTH, REG_FEEDBACK, REG_WET, REG_LFO_INC, REG_CH_COUNT};
    for (int r = 0; r < 6; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Present one word, hold it until taken, then maybe idle
  task automatic send_word(frame_t w);
    int gap;
    in_valid <= 1'b1;
    in_frame <= w;
    do @(posedge clk); while (!in_ready);
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every outstanding word, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  function automatic frame_t random_word();
    frame_t w;
    for (int c = 0; c < FRAME_CH; c++)
      if ($urandom_range(1)) w[c] = 24'($urandom);
      else w[c] = 24'($signed($urandom_range(131071)) - 65536);
    return w;
  endfunction

  task automatic run_phase(int items, int tx, int rx);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    repeat (items) send_word(random_word());
    drain();
  endtask

  initial begin
    frame_t edge_words [$];
    tx_idle_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes under the reset settings
    edge_words = '{{8{24'h7FFFFF}}, {8{24'h800000}}, {8{24'h000000}}, {8{24'hFFFFFF}},
                   {4{24'h7FFFFF, 24'h800000}}, {4{24'h555555, 24'hAAAAAA}},
                   {8{24'h000001}}};
    tx_idle_pct = 15;
    rx_idle_pct = 78;
    foreach (edge_words[i]) send_word(edge_words[i]);
    repeat (8) send_word(random_word());
    drain();

    // One-sample delay, full feedback, fully wet, all lanes
    write_settings(256, 0, 32767, 32768, 0, 8);
    run_phase(130, 15, 78);
    // Zero base delay, feedback of -32768, wet above unity, count above lanes
    write_settings(0, 32767, 32'hFFFF8000, 65535, 32'hFFFFFFFF, 15);
    run_phase(130, 15, 78);
    // Longest delay, fully dry, a few lanes
    write_settings(2096896, 32767, 32'hFFFF8001, 0, 32'h0100_0000, 3);
    run_phase(130, 78, 15);
    // No lane processed
    write_settings($urandom_range(256, 25600), $urandom_range(32767), $urandom,
                   $urandom_range(32768), $urandom, 0);
    run_phase(120, 78, 15);
    // Short random delays with feedback, all idling off
    write_settings($urandom_range(256, 12800), $urandom_range(32767),
                   32'($signed($urandom_range(65534)) - 32767), $urandom_range(32768),
                   $urandom, $urandom_range(1, 8));
    run_phase(130, 0, 0);
    write_settings($urandom_range(256, 51200), $urandom_range(32767),
                   32'($signed($urandom_range(65534)) - 32767), $urandom_range(32768),
                   $urandom_range(32'h0800_0000), $urandom_range(15));
    run_phase(130, 0, 0);

    if (mix_errors == 0)
      $display("chorus_modulated_delay_test OK");
    else
      $display("chorus_modulated_delay_test NOT OK");
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #4ms;
    $display("chorus_modulated_delay_test NOT OK");
    $finish;
  end
endmodule

/* sim.f */
rtl/cmd_pkg.sv
rtl/cmd_ram.sv
rtl/cmd_mod.sv
rtl/cmd_lane.sv
rtl/cmd_merge.sv
rtl/chorus_modulated_delay.sv
rtl/cmd_chk.sv
sim/chorus_modulated_delay_checker.sv
sim/chorus_modulated_delay_test.sv
